>>> hdl/thrd_pkg.sv
// ----------------------------------------------------------------------------
// thrd_pkg
// Types and constants shared by the thermometer report deframer.
// ----------------------------------------------------------------------------
package thrd_pkg;

    localparam int LANES     = 7;
    localparam int NUM_CHARS = 4;
    localparam int FILL_W    = 5;
    localparam int CNT_W     = 32;

    localparam logic [7:0] CHAR_BLANK = 8'h3a;
    localparam logic [7:0] CHAR_MINUS = 8'h3b;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] UNIT_FIRST = 8'h31;
    localparam logic [7:0] UNIT_LAST  = 8'h33;
    localparam logic [7:0] PROBE_CH_1 = 8'h30;
    localparam logic [7:0] PROBE_CH_2 = 8'h31;
    localparam logic [7:0] PROBE_CH_D = 8'h32;
    localparam logic [7:0] PROBE_CH_E = 8'h33;

    localparam logic [FILL_W-1:0] PKT_LEN        = 5'd19;
    localparam logic [FILL_W-1:0] POS_FIRST_CHAR = 5'd1;
    localparam logic [FILL_W-1:0] POS_UNIT       = 5'd5;
    localparam logic [FILL_W-1:0] POS_PROBE      = 5'd13;

    localparam logic [2:0] MAX_PAYLOAD = 3'd7;

    localparam logic [1:0] UNIT_UNKNOWN = 2'd0;
    localparam logic [1:0] PROBE_ONE    = 2'd0;
    localparam logic [1:0] PROBE_TWO    = 2'd1;
    localparam logic [1:0] PROBE_DIFF   = 2'd2;

    typedef enum logic [1:0] {
        KIND_DIGIT,
        KIND_BLANK,
        KIND_MINUS,
        KIND_BAD
    } char_kind_t;

    typedef struct packed {
        logic [NUM_CHARS-1:0] char_hit;
        logic                 unit_hit;
        logic                 probe_hit;
        char_kind_t           kind;
        logic [3:0]           digit;
        logic [1:0]           unit;
        logic [1:0]           probe;
        logic                 probe_ok;
    } lane_info_t;

    typedef struct packed {
        logic signed [14:0] temp;
        logic [1:0]         unit;
        logic [1:0]         probe;
        logic               rel;
        logic               ok;
    } result_t;

endpackage

>>> hdl/thermometer_report_deframer_top.sv
// ----------------------------------------------------------------------------
// thermometer_report_deframer_top
// Appends report payload bytes to a packet, detects CR LF framing and
// returns the decoded temperature word for each 19-byte packet.
// ----------------------------------------------------------------------------
// out_valid rises in the cycle after the accepted report that ends a packet.
// 1 report per cycle unless in_stall; seven byte lanes take it at once.
// in_stall rises only while a result word is held and out_stall is high.
// Reset clears the fill count, packet count, sample limit and output valid;
// the packet field slots hold no reset value and are always written first.
// ----------------------------------------------------------------------------
module thermometer_report_deframer_top (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic               report_whole,
    input  logic [3:0]         payload_count,
    input  logic [7:0]         byte_0,
    input  logic [7:0]         byte_1,
    input  logic [7:0]         byte_2,
    input  logic [7:0]         byte_3,
    input  logic [7:0]         byte_4,
    input  logic [7:0]         byte_5,
    input  logic [7:0]         byte_6,

    input  logic               sample_limit_wr_en,
    input  logic [31:0]        sample_limit_wr_data,

    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [14:0] temperature_tenths,
    output logic [1:0]         unit_code,
    output logic [1:0]         probe_code,
    output logic               relative_reading,
    output logic               reading_valid,
    output logic               limit_reached
);

    localparam int FW = thrd_pkg::FILL_W;
    localparam int CW = thrd_pkg::CNT_W;

    logic [7:0]  bytes [thrd_pkg::LANES];
    logic [2:0]  n_used;
    logic        take;
    logic        crlf;
    logic        fire;
    logic [FW-1:0] fill_sum;

    logic [FW-1:0] fill_reg, fill_next;
    logic [7:0]    last1_reg, last1_next;
    logic [7:0]    last2_reg, last2_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] count_inc;
    logic [CW-1:0] limit_cfg_reg;

    logic              out_valid_reg, out_valid_next;
    thrd_pkg::result_t res_reg;
    logic              hit_limit_reg;

    thrd_pkg::lane_info_t lane_info [thrd_pkg::LANES];
    thrd_pkg::result_t    res_now;

    assign bytes[0] = byte_0;
    assign bytes[1] = byte_1;
    assign bytes[2] = byte_2;
    assign bytes[3] = byte_3;
    assign bytes[4] = byte_4;
    assign bytes[5] = byte_5;
    assign bytes[6] = byte_6;

    assign in_stall = out_valid_reg && out_stall;
    assign take     = in_valid && !in_stall && report_whole;
    assign n_used   = (payload_count > {1'b0, thrd_pkg::MAX_PAYLOAD}) ?
                      thrd_pkg::MAX_PAYLOAD : payload_count[2:0];

    genvar g;
    generate
        for (g = 0; g < thrd_pkg::LANES; g++)
        begin : g_lane
            thrd_lane u_lane (
                .en       (take && (n_used > 3'(g))),
                .position (FW'(fill_reg + FW'(g))),
                .data     (bytes[g]),
                .info     (lane_info[g])
            );
        end
    endgenerate

    thrd_merge u_merge (
        .clk    (clk),
        .lanes  (lane_info),
        .result (res_now)
    );

    always_comb
    begin
        case (n_used)
            3'd0:
            begin
                last1_next = last1_reg;
                last2_next = last2_reg;
            end
            3'd1:
            begin
                last1_next = bytes[0];
                last2_next = last1_reg;
            end
            default:
            begin
                last1_next = bytes[n_used - 3'd1];
                last2_next = bytes[n_used - 3'd2];
            end
        endcase

        fill_sum = fill_reg + {2'b0, n_used};
        crlf     = (fill_sum >= FW'(2)) && (last2_next == thrd_pkg::CHAR_CR) &&
                   (last1_next == thrd_pkg::CHAR_LF);
        fire     = take && crlf && (fill_sum == thrd_pkg::PKT_LEN);

        if (!take)
            fill_next = fill_reg;
        else if (crlf || fill_sum > thrd_pkg::PKT_LEN)
            fill_next = '0;
        else
            fill_next = fill_sum;

        count_inc  = (count_reg == {CW{1'b1}}) ? count_reg : count_reg + CW'(1);
        count_next = fire ? count_inc : count_reg;

        if (fire)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            count_reg     <= '0;
            limit_cfg_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (sample_limit_wr_en)
                limit_cfg_reg <= sample_limit_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            last1_reg <= last1_next;
            last2_reg <= last2_next;
        end
        if (fire)
        begin
            res_reg       <= res_now;
            hit_limit_reg <= (limit_cfg_reg != '0) && (count_inc >= limit_cfg_reg);
        end
    end

    assign out_valid          = out_valid_reg;
    assign temperature_tenths = res_reg.temp;
    assign unit_code          = res_reg.unit;
    assign probe_code         = res_reg.probe;
    assign relative_reading   = res_reg.rel;
    assign reading_valid      = res_reg.ok;
    assign limit_reached      = hit_limit_reg;

    // fill never rests above one packet length
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= thrd_pkg::PKT_LEN)
        else $error("fill count above packet length");

    // a new word never overwrites one that is still held
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> !(out_valid_reg && out_stall))
        else $error("result word overwritten");

    a_fire_shows: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("packet end gave no result word");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res_reg.ok) |-> (res_reg.temp == '0))
        else $error("invalid reading with nonzero temperature");

    a_rel_probe: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (res_reg.rel == (res_reg.probe == thrd_pkg::PROBE_DIFF)))
        else $error("relative flag disagrees with probe code");

endmodule

>>> hdl/thrd_lane.sv
// ----------------------------------------------------------------------------
// thrd_lane
// Classifies one payload byte and flags which packet field it lands in.
// ----------------------------------------------------------------------------
module thrd_lane (
    input  logic                          en,
    input  logic [thrd_pkg::FILL_W-1:0]   position,
    input  logic [7:0]                    data,
    output thrd_pkg::lane_info_t          info
);

    always_comb
    begin
        info = '0;

        for (int k = 0; k < thrd_pkg::NUM_CHARS; k++)
        begin
            info.char_hit[k] = en &&
                (position == thrd_pkg::FILL_W'(thrd_pkg::POS_FIRST_CHAR + k));
        end
        info.unit_hit  = en && (position == thrd_pkg::POS_UNIT);
        info.probe_hit = en && (position == thrd_pkg::POS_PROBE);

        if (data == thrd_pkg::CHAR_BLANK)
            info.kind = thrd_pkg::KIND_BLANK;
        else if (data == thrd_pkg::CHAR_MINUS)
            info.kind = thrd_pkg::KIND_MINUS;
        else if (data >= thrd_pkg::CHAR_ZERO && data <= thrd_pkg::CHAR_NINE)
            info.kind = thrd_pkg::KIND_DIGIT;
        else
            info.kind = thrd_pkg::KIND_BAD;
        info.digit = data[3:0];

        if (data >= thrd_pkg::UNIT_FIRST && data <= thrd_pkg::UNIT_LAST)
            info.unit = data[1:0];
        else
            info.unit = thrd_pkg::UNIT_UNKNOWN;

        info.probe    = thrd_pkg::PROBE_ONE;
        info.probe_ok = 1'b1;
        if (data == thrd_pkg::PROBE_CH_1)
            info.probe = thrd_pkg::PROBE_ONE;
        else if (data == thrd_pkg::PROBE_CH_2)
            info.probe = thrd_pkg::PROBE_TWO;
        else if (data == thrd_pkg::PROBE_CH_D || data == thrd_pkg::PROBE_CH_E)
            info.probe = thrd_pkg::PROBE_DIFF;
        else
            info.probe_ok = 1'b0;
    end

endmodule

>>> hdl/thrd_merge.sv
// ----------------------------------------------------------------------------
// thrd_merge
// Collects the lanes' field bytes into packet slots and decodes the reading.
// ----------------------------------------------------------------------------
module thrd_merge (
    input  logic                  clk,
    input  thrd_pkg::lane_info_t  lanes [thrd_pkg::LANES],
    output thrd_pkg::result_t     result
);

    thrd_pkg::char_kind_t kind_reg  [thrd_pkg::NUM_CHARS];
    thrd_pkg::char_kind_t kind_next [thrd_pkg::NUM_CHARS];
    logic [3:0]           digit_reg  [thrd_pkg::NUM_CHARS];
    logic [3:0]           digit_next [thrd_pkg::NUM_CHARS];
    logic [1:0]           unit_reg, unit_next;
    logic [1:0]           probe_reg, probe_next;
    logic                 probe_ok_reg, probe_ok_next;

    // lane positions are distinct, so at most one lane hits a slot
    always_comb
    begin
        kind_next     = kind_reg;
        digit_next    = digit_reg;
        unit_next     = unit_reg;
        probe_next    = probe_reg;
        probe_ok_next = probe_ok_reg;
        for (int l = 0; l < thrd_pkg::LANES; l++)
        begin
            for (int k = 0; k < thrd_pkg::NUM_CHARS; k++)
            begin
                if (lanes[l].char_hit[k])
                begin
                    kind_next[k]  = lanes[l].kind;
                    digit_next[k] = lanes[l].digit;
                end
            end
            if (lanes[l].unit_hit)
                unit_next = lanes[l].unit;
            if (lanes[l].probe_hit)
            begin
                probe_next    = lanes[l].probe;
                probe_ok_next = lanes[l].probe_ok;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        digit_reg    <= digit_next;
        unit_reg     <= unit_next;
        probe_reg    <= probe_next;
        probe_ok_reg <= probe_ok_next;
    end

    logic [13:0] value;
    logic        neg;
    logic        digits_ok;

    always_comb
    begin
        value     = '0;
        neg       = 1'b0;
        digits_ok = 1'b1;
        for (int k = 0; k < thrd_pkg::NUM_CHARS; k++)
        begin
            case (kind_next[k])
                thrd_pkg::KIND_DIGIT: value = 14'(value * 14'd10) + {10'b0, digit_next[k]};
                thrd_pkg::KIND_MINUS:
                begin
                    if (neg)
                        digits_ok = 1'b0;
                    neg = 1'b1;
                end
                thrd_pkg::KIND_BLANK: ;
                default: digits_ok = 1'b0;
            endcase
        end

        result.ok    = digits_ok && probe_ok_next;
        result.unit  = unit_next;
        result.probe = probe_next;
        result.rel   = (probe_next == thrd_pkg::PROBE_DIFF);
        if (!result.ok)
            result.temp = '0;
        else if (neg)
            result.temp = -$signed({1'b0, value});
        else
            result.temp = $signed({1'b0, value});
    end

endmodule
